// File: src/dead_reckoning_odometry_integrator_unit_macros.svh
// Assertion helpers shared by the modules of the odometry integrator.
// Both sample on the rising edge of clk and stay quiet while rst is high.
`ifndef DEAD_RECKONING_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH
`define DEAD_RECKONING_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH

`define DROU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define DROU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/drou_pkg.sv
package drou_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 144;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [19:0] TIMEOUT_RESET = 20'd200000;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [29:0] HEAD_K = 30'd716770142;

  // The position divisor 1024000000 is 2^16 times this odd factor.
  localparam logic [14:0] POS_DIV_K = 15'd15625;
  // Ceiling of 2^44 / 15625. A dividend below 15625 * 2^16 times this value,
  // shifted right by RECIP_SHIFT, gives the exact quotient by POS_DIV_K.
  localparam logic [30:0] POS_RECIP = 31'd1125899907;
  localparam int unsigned RECIP_SHIFT = 44;

  typedef struct packed {
    logic               timed_out;
    logic signed [15:0] fwd_vel;
    logic signed [15:0] turn_rate;
    logic [31:0]        dt;
  } tick_t;

  // Arctangent of 2^-i as a binary angle, one turn equal to 2^32.
  function automatic logic [29:0] atan_turns(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q2.30 value half up to Q1.14 and clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [34:0] biased;
    logic signed [18:0] r;
    biased = 35'(v) + 35'sd32768;
    r = 19'(biased >>> 16);
    if (r > 19'sd16384) begin
      return 16'sd16384;
    end
    if (r < -19'sd16384) begin
      return -16'sd16384;
    end
    return 16'(r);
  endfunction

endpackage

// File: src/drou_fifo.sv
`include "dead_reckoning_odometry_integrator_unit_macros.svh"

module drou_fifo #(
  parameter int unsigned DEPTH = drou_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  drou_pkg::tick_t wr_data,
  input  logic          pop,
  output drou_pkg::tick_t rd_data,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  drou_pkg::tick_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `DROU_ASSERT_IMPLY(a_no_overflow, push, !full, "tick queue written while full")
  `DROU_ASSERT_IMPLY(a_no_underflow, pop, !empty, "tick queue read while empty")
  `DROU_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "tick queue count beyond depth")

endmodule

// File: src/drou_cordic.sv
module drou_cordic #(
  parameter int unsigned STEPS = drou_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic               done,
  output logic signed [15:0] cos_q14,
  output logic signed [15:0] sin_q14
);

  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] atan_v;
  logic signed [33:0] x_out;
  logic signed [33:0] y_out;
  logic               flip;
  logic               fold;
  logic [31:0]        folded;
  logic [STEP_W-1:0]  step;

  // Angles in the left half plane are turned by half a turn and the result negated.
  assign fold   = angle[31] ^ angle[30];
  assign folded = {angle[31] ^ fold, angle[30:0]};
  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign atan_v = $signed({4'b0000, drou_pkg::atan_turns(5'(step))});
  assign x_out  = flip ? -x : x;
  assign y_out  = flip ? -y : y;
  assign cos_q14 = drou_pkg::to_q14(x_out);
  assign sin_q14 = drou_pkg::to_q14(y_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= drou_pkg::CORDIC_X0;
      y    <= '0;
      z    <= $signed({{2{folded[31]}}, folded});
      flip <= fold;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_v;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_v;
      end
    end
  end

endmodule

// File: src/drou_front.sv
module drou_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [19:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [19:0]        in_elapsed,
  input  logic signed [15:0] in_fwd_vel,
  input  logic signed [15:0] in_turn_rate,
  input  logic               q_full,
  output logic               q_push,
  output drou_pkg::tick_t    q_entry
);

  logic [19:0]        timeout;
  logic [31:0]        since_cmd;
  logic [31:0]        since_tick;
  logic signed [15:0] fwd_vel;
  logic signed [15:0] turn_rate;
  logic [32:0]        cmd_sum;
  logic [32:0]        tick_sum;
  logic [31:0]        cmd_sat;
  logic [31:0]        tick_sat;
  logic               expired;
  logic               accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Both timers saturate instead of wrapping over long gaps.
  assign cmd_sum  = {1'b0, since_cmd} + 33'(in_elapsed);
  assign tick_sum = {1'b0, since_tick} + 33'(in_elapsed);
  assign cmd_sat  = cmd_sum[32] ? '1 : cmd_sum[31:0];
  assign tick_sat = tick_sum[32] ? '1 : tick_sum[31:0];
  assign expired  = cmd_sat > {12'b0, timeout};

  assign q_push            = accept && (in_op == drou_pkg::OP_TICK);
  assign q_entry.timed_out = expired;
  assign q_entry.fwd_vel   = expired ? 16'sd0 : fwd_vel;
  assign q_entry.turn_rate = expired ? 16'sd0 : turn_rate;
  assign q_entry.dt        = tick_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout    <= drou_pkg::TIMEOUT_RESET;
      since_cmd  <= '1;
      since_tick <= '0;
      fwd_vel    <= '0;
      turn_rate  <= '0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (accept) begin
        unique case (in_op)
          drou_pkg::OP_CMD: begin
            fwd_vel    <= in_fwd_vel;
            turn_rate  <= in_turn_rate;
            since_cmd  <= '0;
            since_tick <= tick_sat;
          end
          drou_pkg::OP_TICK: begin
            since_cmd  <= cmd_sat;
            since_tick <= '0;
            if (expired) begin
              fwd_vel   <= '0;
              turn_rate <= '0;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: src/drou_back.sv
`include "dead_reckoning_odometry_integrator_unit_macros.svh"

module drou_back #(
  parameter int unsigned CORDIC_STEPS = drou_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  drou_pkg::tick_t    q_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        pose_x,
  output logic [31:0]        pose_y,
  output logic [15:0]        heading_angle,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] out_fwd_vel,
  output logic signed [15:0] out_turn_rate,
  output logic               timed_out
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ROT  = 10'b00_0000_0010,
    S_MUL1 = 10'b00_0000_0100,
    S_MUL2 = 10'b00_0000_1000,
    S_HEAD = 10'b00_0001_0000,
    S_QHI  = 10'b00_0010_0000,
    S_RHI  = 10'b00_0100_0000,
    S_QLO  = 10'b00_1000_0000,
    S_POS  = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  state_t             state;
  state_t             state_next;
  drou_pkg::tick_t    ent;
  logic [31:0]        heading;
  logic [31:0]        heading_next;
  logic [31:0]        pos_x;
  logic [31:0]        pos_y;
  logic signed [15:0] cos_v;
  logic signed [15:0] sin_v;
  logic signed [30:0] pv_c;
  logic signed [30:0] pv_s;
  logic [29:0]        abs_c;
  logic [29:0]        abs_s;
  logic [15:0]        turn_abs;
  logic [47:0]        prod_t;
  logic [47:0]        tmag;
  logic [61:0]        prod_x;
  logic [61:0]        prod_y;
  logic [60:0]        mx;
  logic [60:0]        my;
  logic               neg_x;
  logic               neg_y;
  logic [61:0]        prod_h1;
  logic [45:0]        prod_h0;
  logic [47:0]        hp1;
  logic [45:0]        hp0;
  logic [47:0]        dh_sum;
  logic [31:0]        dh;
  logic [29:0]        div_x;
  logic [29:0]        div_y;
  logic [60:0]        prod_dx;
  logic [60:0]        prod_dy;
  logic [15:0]        qh_x;
  logic [15:0]        qh_y;
  logic [15:0]        ql_x;
  logic [15:0]        ql_y;
  logic [30:0]        back_x;
  logic [30:0]        back_y;
  logic [13:0]        rem_x;
  logic [13:0]        rem_y;
  logic [31:0]        quo_x;
  logic [31:0]        quo_y;
  logic               out_free;
  logic               cordic_start;
  logic [31:0]        cordic_angle;
  logic               cordic_busy;
  logic               cordic_done;
  logic signed [15:0] cordic_cos;
  logic signed [15:0] cordic_sin;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  // First rotation gives the old heading; the second gives half the new heading.
  assign cordic_start = q_pop || (state == S_HEAD);
  assign cordic_angle = q_pop ? heading : {1'b0, heading_next[31:1]};

  drou_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (cordic_angle),
    .busy    (cordic_busy),
    .done    (cordic_done),
    .cos_q14 (cordic_cos),
    .sin_q14 (cordic_sin)
  );

  assign turn_abs = ent.turn_rate[15] ? 16'(-ent.turn_rate) : 16'(ent.turn_rate);
  assign prod_t   = turn_abs * ent.dt;
  assign abs_c    = pv_c[30] ? 30'(-pv_c) : 30'(pv_c);
  assign abs_s    = pv_s[30] ? 30'(-pv_s) : 30'(pv_s);
  assign prod_x   = abs_c * ent.dt;
  assign prod_y   = abs_s * ent.dt;
  assign prod_h1  = tmag[47:16] * drou_pkg::HEAD_K;
  assign prod_h0  = tmag[15:0] * drou_pkg::HEAD_K;
  assign dh_sum   = hp1 + 48'(hp0[45:16]);
  assign dh       = dh_sum[47:16];
  assign heading_next = ent.turn_rate[15] ? heading - dh : heading + dh;

  // The scaled magnitude is divided by the odd part of the divisor one 16-bit
  // quotient digit at a time, each digit by reciprocal multiplication.
  assign prod_dx = div_x * drou_pkg::POS_RECIP;
  assign prod_dy = div_y * drou_pkg::POS_RECIP;
  assign back_x  = qh_x * drou_pkg::POS_DIV_K;
  assign back_y  = qh_y * drou_pkg::POS_DIV_K;
  assign rem_x   = 14'(div_x - back_x[29:0]);
  assign rem_y   = 14'(div_y - back_y[29:0]);
  assign quo_x   = {qh_x, ql_x};
  assign quo_y   = {qh_y, ql_y};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (!q_empty) state_next = S_ROT;
      S_ROT:  if (cordic_done) state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_HEAD;
      S_HEAD: state_next = S_QHI;
      S_QHI:  state_next = S_RHI;
      S_RHI:  state_next = S_QLO;
      S_QLO:  if (!cordic_busy) state_next = S_POS;
      S_POS:  state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      heading   <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_HEAD) begin
        heading <= heading_next;
      end
      if (state == S_POS) begin
        pos_x <= pos_x + (neg_x ? -quo_x : quo_x);
        pos_y <= pos_y + (neg_y ? -quo_y : quo_y);
      end
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent <= q_entry;
    end
    if ((state == S_ROT) && cordic_done) begin
      cos_v <= cordic_cos;
      sin_v <= cordic_sin;
    end
    if (state == S_MUL1) begin
      pv_c <= 31'(32'(ent.fwd_vel) * 32'(cos_v));
      pv_s <= 31'(32'(ent.fwd_vel) * 32'(sin_v));
      tmag <= prod_t;
    end
    if (state == S_MUL2) begin
      mx    <= prod_x[60:0];
      my    <= prod_y[60:0];
      neg_x <= pv_c[30];
      neg_y <= pv_s[30];
      hp1   <= prod_h1[47:0];
      hp0   <= prod_h0;
    end
    if (state == S_HEAD) begin
      div_x <= {1'b0, mx[60:32]};
      div_y <= {1'b0, my[60:32]};
    end
    if (state == S_QHI) begin
      qh_x <= prod_dx[drou_pkg::RECIP_SHIFT +: 16];
      qh_y <= prod_dy[drou_pkg::RECIP_SHIFT +: 16];
    end
    if (state == S_RHI) begin
      div_x <= {rem_x, mx[31:16]};
      div_y <= {rem_y, my[31:16]};
    end
    if (state == S_QLO) begin
      ql_x <= prod_dx[drou_pkg::RECIP_SHIFT +: 16];
      ql_y <= prod_dy[drou_pkg::RECIP_SHIFT +: 16];
    end
    if ((state == S_EMIT) && out_free) begin
      pose_x        <= pos_x;
      pose_y        <= pos_y;
      heading_angle <= heading[31:16];
      quat_z        <= cordic_sin;
      quat_w        <= cordic_cos;
      out_fwd_vel   <= ent.fwd_vel;
      out_turn_rate <= ent.turn_rate;
      timed_out     <= ent.timed_out;
    end
  end

  `DROU_ASSERT_IMPLY(a_pos_rot_idle, state == S_POS, !cordic_busy, "half-angle rotation still running")
  `DROU_ASSERT_IMPLY(a_result_from_emit, $rose(out_valid), $past(state) == S_EMIT, "result raised outside emit")

endmodule

// File: src/dead_reckoning_odometry_integrator_unit.sv
// Dead-reckoning odometry integrator for a differential-drive base.
// The input stream carries one beat per event: tuser 0 is a velocity command,
// tuser 1 an integration tick; every beat carries the microseconds since the
// previous beat. A command beat produces no output. Each tick beat produces
// one output beat with the pose, the yaw quaternion, the velocities in effect
// and, in tuser, whether the command timeout forced the velocities to zero.
// The timeout register is to be written through cfg_we and cfg_wdata only
// while idle; the block does not enforce this. Timers and commands are handled in
// the cycle a beat is accepted; ticks wait in a small queue for the integrator,
// which takes one tick at a time, popping the next only after the last result
// is emitted. Each tick uses two passes of the shared rotation unit; the position
// division, in states S_QHI, S_RHI and S_QLO, runs under the second pass. Command
// beats are taken every cycle while the queue has room. A result waits in the
// output register while the receiver stalls; the queue keeps accepting until
// QUEUE_DEPTH ticks are pending, then tready falls. Reset clears the pose and
// velocities, loads the timeout with 200000 us and starts with the command timer
// expired.
module dead_reckoning_odometry_integrator_unit #(
  parameter int unsigned CORDIC_STEPS = drou_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned QUEUE_DEPTH  = drou_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [19:0]                         cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // elapsed_us, cmd_forward_vel, cmd_turn_rate
  input  logic [drou_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pose_x, pose_y, heading_angle, quat_z, quat_w, out_forward_vel, out_turn_rate
  output logic [drou_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // timed_out
  output logic                                m_axis_tuser
);

  drou_pkg::tick_t    push_entry;
  drou_pkg::tick_t    head_entry;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic [31:0]        pose_x;
  logic [31:0]        pose_y;
  logic [15:0]        heading_angle;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] out_fwd_vel;
  logic signed [15:0] out_turn_rate;

  drou_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_op        (s_axis_tuser),
    .in_elapsed   (s_axis_tdata[19:0]),
    .in_fwd_vel   ($signed(s_axis_tdata[35:20])),
    .in_turn_rate ($signed(s_axis_tdata[51:36])),
    .q_full       (full),
    .q_push       (push),
    .q_entry      (push_entry)
  );

  drou_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .pop     (pop),
    .rd_data (head_entry),
    .full    (full),
    .empty   (empty)
  );

  drou_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (empty),
    .q_pop         (pop),
    .q_entry       (head_entry),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .pose_x        (pose_x),
    .pose_y        (pose_y),
    .heading_angle (heading_angle),
    .quat_z        (quat_z),
    .quat_w        (quat_w),
    .out_fwd_vel   (out_fwd_vel),
    .out_turn_rate (out_turn_rate),
    .timed_out     (m_axis_tuser)
  );

  assign m_axis_tdata = {out_turn_rate, out_fwd_vel, quat_w, quat_z,
                         heading_angle, pose_y, pose_x};

endmodule
